// File: src/dau_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the duration arithmetic unit.
package dau_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NEG  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Default day counter width
    localparam int DAY_BITS_DEF = 16;

    // Magnitude width of the scalar (|-2^31| still fits)
    localparam int MAG_BITS = 32;

    // Time unit weights
    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    // Reciprocals for splitting the seconds within one day
    localparam logic [15:0] RCP_HOUR = 16'd37283;  // 2^27 / 3600, rounded up
    localparam logic [11:0] RCP_MIN  = 12'd2185;   // 2^17 / 60, rounded up

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        a_days;
        logic [4:0]         a_hours;
        logic [5:0]         a_minutes;
        logic [5:0]         a_seconds;
        logic [15:0]        b_days;
        logic [4:0]         b_hours;
        logic [5:0]         b_minutes;
        logic [5:0]         b_seconds;
        logic signed [31:0] scalar;
    } t_req;

    typedef struct packed {
        logic [15:0] res_days;
        logic [4:0]  res_hours;
        logic [5:0]  res_minutes;
        logic [5:0]  res_seconds;
        logic [1:0]  status;
    } t_rsp;

endpackage

// File: src/dau_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
interface dau_req_if;
    logic           valid;
    logic           ready;
    dau_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dau_rsp_if;
    logic           valid;
    logic           ready;
    dau_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/duration_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Duration arithmetic unit: add, subtract, scale and divide day/h/m/s durations.
//
// Usage: a request on i_req carries an opcode, durations A and B and a signed
// scalar; one result (days, hours, minutes, seconds, status) leaves on o_rsp
// for each request, in request order. Both channels are valid/ready; a
// request or result moves at a clock edge with valid and ready high.
// Throughput: one request per cycle unless o_rsp stalls. Two front stages
// form total seconds and the add/subtract result, one stage per bit runs
// the shift-add multiplier and the restoring divider side by side, one
// stage selects the result and status, three stages split off whole days
// by a reciprocal multiply, and two reciprocal multiplies give hours,
// minutes and seconds.
// Reset (i_rst_n low, synchronous) drops every request in flight.
// When the receiver holds o_rsp.ready low with a result waiting, the whole
// pipe freezes and i_req.ready falls; nothing is lost or repeated.
module duration_arithmetic_unit_core #(
    parameter int DAY_BITS = dau_pkg::DAY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dau_req_if.sink   i_req,
    dau_rsp_if.source o_rsp
);
    import dau_pkg::*;

    localparam int SEC_BITS = DAY_BITS + 17;
    localparam int ACC_BITS = SEC_BITS + 2;
    localparam int NSTEP    = (SEC_BITS > MAG_BITS) ? SEC_BITS : MAG_BITS;
    localparam logic [SEC_BITS-1:0] SEC_LIMIT =
        SEC_BITS'((64'd1 << DAY_BITS) * 64'(SEC_PER_DAY) - 64'd1);

    // Day split: days = (secs >> 7) / 675 by reciprocal, in two partial products
    localparam int XB = SEC_BITS - 7;
    localparam int DK = XB + 10;
    localparam int MB = XB + 1;
    localparam int ML = MB / 2;
    localparam int MH = MB - ML;
    localparam int PB = XB + MB;
    localparam logic [MB-1:0] DRCP = MB'(((64'd1 << DK) + 64'd674) / 64'd675);

    typedef struct packed {
        logic [1:0]          op;
        logic                sneg;
        logic                subneg;
        logic [SEC_BITS-1:0] ta;
        logic [MAG_BITS-1:0] mag;
        logic [ACC_BITS-1:0] acc;
        logic                movf;
        logic [MAG_BITS-1:0] rem;
        logic [NSTEP-1:0]    q;
    } t_it;

    typedef struct packed {
        logic [1:0]          op;
        logic                sneg;
        logic [SEC_BITS-1:0] ta;
        logic [SEC_BITS-1:0] tb;
        logic [MAG_BITS-1:0] mag;
    } t_fr;

    typedef struct packed {
        logic [1:0]          st;
        logic [SEC_BITS-1:0] rem;
    } t_sel;

    typedef struct packed {
        logic [1:0]          st;
        logic [SEC_BITS-1:0] rem;
        logic [XB-1:0]       xs;
        logic [XB+ML-1:0]    plo;
    } t_d1;

    typedef struct packed {
        logic [1:0]          st;
        logic [SEC_BITS-1:0] rem;
        logic [DAY_BITS-1:0] days;
    } t_dv;

    typedef struct packed {
        logic [1:0]          st;
        logic [DAY_BITS-1:0] days;
        logic [16:0]         sday;
    } t_d3;

    typedef struct packed {
        logic [1:0]          st;
        logic [DAY_BITS-1:0] days;
        logic [4:0]          hours;
        logic [11:0]         rh;
    } t_hr;

    logic en;

    // Advance the whole pipe unless a result waits on a stalled receiver
    assign en          = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    // Front stage 1: total seconds and scalar magnitude
    logic r_fv;
    t_fr  r_fr;
    t_fr  n_fr;
    logic [DAY_BITS-1:0] a_d;
    logic [DAY_BITS-1:0] b_d;
    logic [31:0]         s_raw;

    always_comb begin
        a_d      = DAY_BITS'(i_req.payload.a_days);
        b_d      = DAY_BITS'(i_req.payload.b_days);
        s_raw    = i_req.payload.scalar;
        n_fr.op  = i_req.payload.op;
        n_fr.sneg = s_raw[31];
        n_fr.mag = s_raw[31] ? MAG_BITS'(~s_raw + 32'd1) : MAG_BITS'(s_raw);
        n_fr.ta  = SEC_BITS'(a_d) * SEC_BITS'(SEC_PER_DAY)
                 + SEC_BITS'(i_req.payload.a_hours) * SEC_BITS'(SEC_PER_HOUR)
                 + SEC_BITS'(i_req.payload.a_minutes) * SEC_BITS'(SEC_PER_MIN)
                 + SEC_BITS'(i_req.payload.a_seconds);
        n_fr.tb  = SEC_BITS'(b_d) * SEC_BITS'(SEC_PER_DAY)
                 + SEC_BITS'(i_req.payload.b_hours) * SEC_BITS'(SEC_PER_HOUR)
                 + SEC_BITS'(i_req.payload.b_minutes) * SEC_BITS'(SEC_PER_MIN)
                 + SEC_BITS'(i_req.payload.b_seconds);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en) begin
            r_fv <= i_req.valid;
        end
        if (en) begin
            r_fr <= n_fr;
        end
    end

    // Front stage 2: add/subtract result and iteration setup
    logic r_iv [0:NSTEP];
    t_it  r_it [0:NSTEP];
    t_it  n_it0;

    always_comb begin
        n_it0.op     = r_fr.op;
        n_it0.sneg   = r_fr.sneg;
        n_it0.subneg = r_fr.tb > r_fr.ta;
        n_it0.ta     = r_fr.ta;
        n_it0.mag    = r_fr.mag;
        n_it0.movf   = 1'b0;
        n_it0.rem    = '0;
        n_it0.q      = '0;
        case (r_fr.op)
            OP_ADD:  n_it0.acc = ACC_BITS'(r_fr.ta) + ACC_BITS'(r_fr.tb);
            OP_SUB:  n_it0.acc = n_it0.subneg ? '0
                               : ACC_BITS'(r_fr.ta) - ACC_BITS'(r_fr.tb);
            default: n_it0.acc = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv[0] <= 1'b0;
        end else if (en) begin
            r_iv[0] <= r_fv;
        end
        if (en) begin
            r_it[0] <= n_it0;
        end
    end

    // Bit stages: one multiplier bit and one quotient bit each, MSB first
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        t_it                 s;
        t_it                 n_s;
        logic [NSTEP-1:0]    magp;
        logic [NSTEP-1:0]    tap;
        logic [ACC_BITS-1:0] nacc;
        logic [MAG_BITS:0]   trial;

        always_comb begin
            s     = r_it[k];
            n_s   = s;
            magp  = NSTEP'(s.mag);
            tap   = NSTEP'(s.ta);
            nacc  = {s.acc[ACC_BITS-2:0], 1'b0}
                  + (magp[NSTEP-1-k] ? ACC_BITS'(s.ta) : '0);
            trial = {s.rem, tap[NSTEP-1-k]};
            // shift-add multiply, saturating once past the limit
            if (s.op == OP_MUL && !s.movf) begin
                n_s.acc = nacc;
                if (nacc > ACC_BITS'(SEC_LIMIT)) begin
                    n_s.movf = 1'b1;
                end
            end
            // restoring divide step
            if (trial >= {1'b0, s.mag}) begin
                n_s.rem          = MAG_BITS'(trial - {1'b0, s.mag});
                n_s.q[NSTEP-1-k] = 1'b1;
            end else begin
                n_s.rem = trial[MAG_BITS-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_iv[k+1] <= 1'b0;
            end else if (en) begin
                r_iv[k+1] <= r_iv[k];
            end
            if (en) begin
                r_it[k+1] <= n_s;
            end
        end
    end

    // Result select and status, priority divide-by-zero, sign, overflow
    logic r_selv;
    t_sel r_sel;
    t_sel n_sel;
    t_it  e;

    always_comb begin
        e         = r_it[NSTEP];
        n_sel.st  = ST_OK;
        n_sel.rem = '0;
        case (e.op) inside
            OP_ADD, OP_SUB: begin
                if (e.op == OP_SUB && e.subneg) begin
                    n_sel.st = ST_NEG;
                end else if (e.acc > ACC_BITS'(SEC_LIMIT)) begin
                    n_sel.st = ST_OVF;
                end else begin
                    n_sel.rem = SEC_BITS'(e.acc);
                end
            end
            OP_MUL: begin
                if (e.ta == '0 || e.mag == '0) begin
                    n_sel.rem = '0;
                end else if (e.sneg) begin
                    n_sel.st = ST_NEG;
                end else if (e.movf) begin
                    n_sel.st = ST_OVF;
                end else begin
                    n_sel.rem = SEC_BITS'(e.acc);
                end
            end
            default: begin
                if (e.mag == '0) begin
                    n_sel.st = ST_DIV0;
                end else if (e.sneg && e.q != '0) begin
                    n_sel.st = ST_NEG;
                end else if (e.q > NSTEP'(SEC_LIMIT)) begin
                    n_sel.st = ST_OVF;
                end else begin
                    n_sel.rem = SEC_BITS'(e.q);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selv <= 1'b0;
        end else if (en) begin
            r_selv <= r_iv[NSTEP];
        end
        if (en) begin
            r_sel <= n_sel;
        end
    end

    // Day stage 1: low partial product of seconds/128 times the reciprocal
    logic r_d1v;
    t_d1  r_d1;
    t_d1  n_d1;

    always_comb begin
        n_d1.st  = r_sel.st;
        n_d1.rem = r_sel.rem;
        n_d1.xs  = r_sel.rem[SEC_BITS-1:7];
        n_d1.plo = (XB+ML)'(n_d1.xs) * (XB+ML)'(DRCP[ML-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1v <= 1'b0;
        end else if (en) begin
            r_d1v <= r_selv;
        end
        if (en) begin
            r_d1 <= n_d1;
        end
    end

    // Day stage 2: add the high partial product and take whole days
    logic            r_d2v;
    t_dv             r_d2;
    t_dv             n_d2;
    logic [XB+MH-1:0] phi;
    logic [PB-1:0]   dprod;

    always_comb begin
        phi       = (XB+MH)'(r_d1.xs) * (XB+MH)'(DRCP[MB-1:ML]);
        dprod     = PB'(r_d1.plo) + {phi, {ML{1'b0}}};
        n_d2.st   = r_d1.st;
        n_d2.rem  = r_d1.rem;
        n_d2.days = dprod[DK +: DAY_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2v <= 1'b0;
        end else if (en) begin
            r_d2v <= r_d1v;
        end
        if (en) begin
            r_d2 <= n_d2;
        end
    end

    // Day stage 3: seconds left within the day
    logic                r_d3v;
    t_d3                 r_d3;
    t_d3                 n_d3;
    logic [SEC_BITS-1:0] dsec;

    always_comb begin
        dsec      = SEC_BITS'(r_d2.days) * SEC_BITS'(SEC_PER_DAY);
        n_d3.st   = r_d2.st;
        n_d3.days = r_d2.days;
        n_d3.sday = 17'(r_d2.rem - dsec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3v <= 1'b0;
        end else if (en) begin
            r_d3v <= r_d2v;
        end
        if (en) begin
            r_d3 <= n_d3;
        end
    end

    // Hour stage: seconds within the day to hours and rest of the hour
    logic        r_hv;
    t_hr         r_hr;
    t_hr         n_hr;
    logic [16:0] sday;
    logic [32:0] hprod;
    logic [16:0] hsec;

    always_comb begin
        sday       = r_d3.sday;
        hprod      = 33'(sday) * 33'(RCP_HOUR);
        n_hr.st    = r_d3.st;
        n_hr.days  = r_d3.days;
        n_hr.hours = hprod[31:27];
        hsec       = 17'(n_hr.hours) * 17'(SEC_PER_HOUR);
        n_hr.rh    = 12'(sday - hsec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (en) begin
            r_hv <= r_d3v;
        end
        if (en) begin
            r_hr <= n_hr;
        end
    end

    // Output stage: minutes and seconds, hold while the receiver stalls
    logic        r_ov;
    t_rsp        r_rsp;
    t_rsp        n_rsp;
    logic [22:0] mprod;
    logic [11:0] msec;

    always_comb begin
        mprod             = 23'(r_hr.rh) * 23'(RCP_MIN);
        n_rsp.res_days    = 16'(r_hr.days);
        n_rsp.res_hours   = r_hr.hours;
        n_rsp.res_minutes = mprod[22:17];
        msec              = 12'(n_rsp.res_minutes) * 12'(SEC_PER_MIN);
        n_rsp.res_seconds = 6'(r_hr.rh - msec);
        n_rsp.status      = r_hr.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_hv;
        end
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_rsp;

endmodule

// File: test/dau_checker.sv
`timescale 1ns / 1ps
// Checker for the duration arithmetic unit: predicts each result and compares it.
module dau_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dau_req_if         i_req,
    dau_rsp_if         i_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    import dau_pkg::*;

    localparam longint unsigned DAYS_MAX  = 64'd65535;
    localparam longint unsigned SECS_CEIL = (DAYS_MAX + 1) * 86400 - 1;

    t_rsp expected_rsp_q[$];

    // Compute the expected result for one request
    function automatic t_rsp predict_duration(t_req r);
        longint unsigned ta, tb, mag, secs;
        logic [1:0]      st;
        logic            neg;
        t_rsp            o;
        ta = r.a_days * 64'd86400 + r.a_hours * 64'd3600 + r.a_minutes * 64'd60
             + r.a_seconds;
        tb = r.b_days * 64'd86400 + r.b_hours * 64'd3600 + r.b_minutes * 64'd60
             + r.b_seconds;
        neg = r.scalar[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, r.scalar}) : {32'd0, r.scalar};
        secs = 0;
        st = ST_OK;
        case (r.op)
            OP_ADD: secs = ta + tb;
            OP_SUB: begin
                if (tb > ta) st = ST_NEG;
                else secs = ta - tb;
            end
            OP_MUL: begin
                if (ta == 0 || mag == 0) secs = 0;
                else if (neg) st = ST_NEG;
                else if (ta > SECS_CEIL / mag) st = ST_OVF;
                else secs = ta * mag;
            end
            default: begin
                if (mag == 0) st = ST_DIV0;
                else begin
                    secs = ta / mag;
                    if (neg && secs != 0) st = ST_NEG;
                end
            end
        endcase
        if (st == ST_OK && secs > SECS_CEIL) st = ST_OVF;
        o = '0;
        o.status = st;
        if (st == ST_OK) begin
            o.res_days    = 16'(secs / 86400);
            o.res_hours   = 5'((secs / 3600) % 24);
            o.res_minutes = 6'((secs / 60) % 60);
            o.res_seconds = 6'(secs % 60);
        end
        return o;
    endfunction

    assign o_pending = expected_rsp_q.size();

    // Queue predictions on request, compare on result
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            expected_rsp_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(predict_duration(i_req.payload));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result %p", $realtime, i_rsp.payload);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (want !== i_rsp.payload) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, i_rsp.payload);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and result back-pressure, gives the verdict.
module tb_top;
    import dau_pkg::*;

    localparam int LATENCY   = 41;
    localparam int NUM_RAND  = 800;
    localparam int IDLE_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   stim_done;

    dau_req_if req_ch ();
    dau_rsp_if rsp_ch ();

    duration_arithmetic_unit_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    dau_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random duration field values, leaning toward the edges
    function automatic logic [15:0] rand_days();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req rand_request();
        t_req r;
        r = '0;
        r.op        = 2'($urandom);
        r.a_days    = rand_days();
        r.a_hours   = 5'($urandom);
        r.a_minutes = 6'($urandom);
        r.a_seconds = 6'($urandom);
        r.b_days    = rand_days();
        r.b_hours   = 5'($urandom);
        r.b_minutes = 6'($urandom);
        r.b_seconds = 6'($urandom);
        case ($urandom_range(0, 5))
            0: r.scalar = 32'sd0;
            1: r.scalar = $signed(32'($urandom_range(1, 100)));
            2: r.scalar = -$signed(32'($urandom_range(1, 100)));
            3: r.scalar = 32'sh8000_0000;
            default: r.scalar = $signed($urandom);
        endcase
        // keep the product mostly in range so results are not all overflow
        if (r.op == OP_MUL && $urandom_range(0, 1)) r.a_days = 16'($urandom_range(0, 20));
        return r;
    endfunction

    // Send one request, holding it until accepted
    task automatic send_request(input t_req r);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] op, logic [15:0] ad, logic [4:0] ah,
                                logic [5:0] am, logic [5:0] as_, logic [15:0] bd,
                                logic signed [31:0] sc);
        t_req r;
        r = '0;
        r.op = op; r.a_days = ad; r.a_hours = ah; r.a_minutes = am; r.a_seconds = as_;
        r.b_days = bd; r.scalar = sc;
        return r;
    endfunction

    // Request stimulus
    initial begin
        t_req dir_q[$];
        stim_done      = 1'b0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, each op, error cases, unnormalized fields
        dir_q.push_back(mk(OP_ADD, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0, 32'sd0));
        dir_q.push_back(mk(OP_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0, 32'sd0));
        dir_q.push_back(mk(OP_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd1, 32'sd5));
        dir_q.push_back(mk(OP_ADD, 16'd1, 5'd31, 6'd63, 6'd63, 16'hFFFF, 32'sd0));
        dir_q.push_back(mk(OP_SUB, 16'd5, 5'd0, 6'd0, 6'd0, 16'd5, 32'sd0));
        dir_q.push_back(mk(OP_SUB, 16'd4, 5'd0, 6'd0, 6'd0, 16'd5, 32'sd0));
        dir_q.push_back(mk(OP_SUB, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'd0, -32'sd1));
        dir_q.push_back(mk(OP_MUL, 16'd0, 5'd0, 6'd0, 6'd0, 16'd9, -32'sd7));
        dir_q.push_back(mk(OP_MUL, 16'd3, 5'd1, 6'd2, 6'd3, 16'd0, 32'sd0));
        dir_q.push_back(mk(OP_MUL, 16'd3, 5'd1, 6'd2, 6'd3, 16'd0, -32'sd2));
        dir_q.push_back(mk(OP_MUL, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0, 32'sd65535));
        dir_q.push_back(mk(OP_MUL, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0, 32'sd65536));
        dir_q.push_back(mk(OP_MUL, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'd0, 32'sh7FFF_FFFF));
        dir_q.push_back(mk(OP_MUL, 16'd2, 5'd0, 6'd0, 6'd0, 16'd0, 32'sh8000_0000));
        dir_q.push_back(mk(OP_DIV, 16'd7, 5'd0, 6'd0, 6'd1, 16'd0, 32'sd0));
        dir_q.push_back(mk(OP_DIV, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0, 32'sd0));
        dir_q.push_back(mk(OP_DIV, 16'd7, 5'd0, 6'd0, 6'd1, 16'd0, 32'sd3));
        dir_q.push_back(mk(OP_DIV, 16'd7, 5'd0, 6'd0, 6'd1, 16'd0, -32'sd3));
        dir_q.push_back(mk(OP_DIV, 16'd0, 5'd0, 6'd0, 6'd5, 16'd0, -32'sd7));
        dir_q.push_back(mk(OP_DIV, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'd0, 32'sh8000_0000));
        dir_q.push_back(mk(OP_DIV, 16'hFFFF, 5'd31, 6'd63, 6'd63, 16'd0, 32'sd1));
        foreach (dir_q[i]) send_request(dir_q[i]);
        repeat (NUM_RAND) send_request(rand_request());
        req_ch.valid <= 1'b0;
        // let the checker record the last request before declaring the end
        @(posedge i_clk);
        stim_done = 1'b1;
    end

    // Result back-pressure, with one long hold-off while requests keep coming
    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        repeat (200) @(posedge i_clk);
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        forever begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Watchdog and end of run
    initial begin
        int idle;
        idle = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
            if (stim_done && pending == 0) begin
                repeat (LATENCY + 20) @(posedge i_clk);
                if (fail_count == 0 && pending == 0) begin
                    $display("tb_top: PASS");
                end else begin
                    $display("tb_top: FAIL");
                end
                $finish;
            end
        end
    end
endmodule
